// File: rtl/core/srrw_pkg.sv
// ----------------------------------------------------------------------------
// srrw_pkg
// Types and constants shared by the selective-repeat receive window core.
// ----------------------------------------------------------------------------
package srrw_pkg;

    localparam int SEQ_W     = 32;  // sequence number / ack number width
    localparam int LEN_W     = 12;  // payload length width
    localparam int TAG_W     = 16;  // payload handle width
    localparam int TOT_W     = 32;  // byte total width
    localparam int WS_W      = 6;   // window size register width
    localparam int ALU_W     = 34;  // two's complement width of the shared unit
    localparam int BIT_CNT_W = 5;   // bit counter over SEQ_W bits of the base

    // input segment kinds
    localparam logic IN_KIND_DATA = 1'b0;
    localparam logic IN_KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_END_ACK = 2'd2
    } t_out_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP_BASE,
        ST_CMP_WIN,
        ST_ACK,
        ST_DLV,
        ST_RD,
        ST_REL,
        ST_END,
        ST_MOD
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
    } t_alu_res;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } t_slot_data;

endpackage

// File: rtl/core/srrw_alu.sv
// ----------------------------------------------------------------------------
// srrw_alu
// Shared add/subtract unit: window compares and the base remainder pass.
// ----------------------------------------------------------------------------
module srrw_alu (
    input  srrw_pkg::t_alu_req i_req,
    output srrw_pkg::t_alu_res o_res
);
    import srrw_pkg::*;

    logic [ALU_W-1:0] sum;

    always_comb begin
        unique case (i_req.op)
            ALU_ADD: sum = i_req.a + i_req.b;
            ALU_SUB: sum = i_req.a - i_req.b;
        endcase
        o_res.sum = sum;
        o_res.neg = sum[ALU_W-1];
    end

endmodule

// File: rtl/core/srrw_slot_mem.sv
// ----------------------------------------------------------------------------
// srrw_slot_mem
// Slot store for buffered segments: tag and length, registered read.
// ----------------------------------------------------------------------------
module srrw_slot_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  srrw_pkg::t_slot_data i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output srrw_pkg::t_slot_data o_rdata
);
    import srrw_pkg::*;

    t_slot_data mem [DEPTH];
    t_slot_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/selective_repeat_receive_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Selective-repeat receiver window over segment descriptors: acks, in-order
// delivery, buffering of out-of-order segments and end-of-transfer acks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready     | kind, seq, cksum, len, tag
//  out     | output    | o_out_valid / i_out_ready   | kind, ack, tag, len, total
//  cfg     | input     | i_cfg_we                    | window size
//
//  Data segment: base and window compares on the shared unit, then a result
//  each (ack, deliver); each buffered segment released takes a slot read and
//  then an emit. End segment: one end ack. Dropped segments: both compares
//  (only the base compare when the seq is past the sequence limit), no result.
//  A window size write starts a remainder pass (base mod N, one bit per cycle on
//  the shared unit); no segment is accepted during it.
//  Reset: window size 1, base 1, no slot marked, byte total 0.
//  A stalled output holds the sequencer in its emit state.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
    parameter int WINDOW_MAX  = 32,
    parameter int SEQ_BITS    = 32,
    parameter int MAX_PAYLOAD = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [srrw_pkg::WS_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [srrw_pkg::SEQ_W-1:0]  i_seq_num,
    input  logic                        i_checksum_ok,
    input  logic [srrw_pkg::LEN_W-1:0]  i_length,
    input  logic [srrw_pkg::TAG_W-1:0]  i_payload_tag,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_out_kind,
    output logic [srrw_pkg::SEQ_W-1:0]  o_ack_num,
    output logic [srrw_pkg::TAG_W-1:0]  o_deliver_tag,
    output logic [srrw_pkg::LEN_W-1:0]  o_deliver_length,
    output logic [srrw_pkg::TOT_W-1:0]  o_total_bytes,
    output logic                        o_last
);
    import srrw_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int N_W   = $clog2(WINDOW_MAX + 1);
    localparam logic [SEQ_W:0] SEQ_MAX = (SEQ_W + 1)'((64'd1 << SEQ_BITS) - 64'd1);
    localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_PAYLOAD);

    // control state
    t_state               r_state, n_state;
    logic [WS_W-1:0]      r_win_size, n_win_size;
    logic [SEQ_W-1:0]     r_base, n_base;
    logic [IDX_W-1:0]     r_base_idx, n_base_idx;
    logic [WINDOW_MAX-1:0] r_filled, n_filled;
    logic [TOT_W-1:0]     r_total, n_total;
    logic                 r_inord, n_inord;
    logic [N_W-1:0]       r_rem, n_rem;
    logic [BIT_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_ovalid, n_ovalid;

    // item and result payload
    logic [SEQ_W-1:0]     r_seq, n_seq;
    logic                 r_good, n_good;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [TAG_W-1:0]     r_tag, n_tag;
    logic [ALU_W-1:0]     r_d, n_d;
    t_out_kind            r_okind, n_okind;
    logic [SEQ_W-1:0]     r_oack, n_oack;
    logic [TAG_W-1:0]     r_otag, n_otag;
    logic [LEN_W-1:0]     r_olen, n_olen;
    logic [TOT_W-1:0]     r_ototal, n_ototal;
    logic                 r_olast, n_olast;

    t_alu_req             alu_req;
    t_alu_res             alu_res;
    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr;
    t_slot_data           mem_wdata, mem_rdata;

    logic [6:0]           ws_ext;
    logic [N_W-1:0]       n;
    logic [N_W-1:0]       idx_ext, idx_plus;
    logic                 base_at_max;
    logic [IDX_W-1:0]     next_idx;
    logic                 rel_last;
    logic [N_W:0]         st_sum, st_red;
    logic [IDX_W-1:0]     st_idx;
    logic [LEN_W-1:0]     dlv_len;
    logic [TOT_W:0]       tot_sum;
    logic [TOT_W-1:0]     tot_sat;
    logic                 out_free;
    logic [N_W:0]         rem_shift;
    logic [N_W-1:0]       rem_next;

    srrw_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    srrw_slot_mem #(
        .DEPTH (WINDOW_MAX),
        .AW    (IDX_W)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_base_idx),
        .o_rdata (mem_rdata)
    );

    // effective window: 0 acts as 1, clamp at WINDOW_MAX
    always_comb begin
        ws_ext = {1'b0, r_win_size};
        if (r_win_size == '0) begin
            n = N_W'(1);
        end else if (int'(r_win_size) > WINDOW_MAX) begin
            n = N_W'(WINDOW_MAX);
        end else begin
            n = ws_ext[N_W-1:0];
        end
    end

    // base advance and slot index of the next base
    always_comb begin
        idx_ext     = N_W'(r_base_idx);
        idx_plus    = idx_ext + N_W'(1);
        base_at_max = ({1'b0, r_base} == SEQ_MAX);
        if (base_at_max) begin
            next_idx = r_base_idx;
        end else if (idx_plus == n) begin
            next_idx = '0;
        end else begin
            next_idx = idx_plus[IDX_W-1:0];
        end
        // current slot is cleared on release, so a stuck index ends the run
        rel_last = base_at_max || (next_idx == r_base_idx) || !r_filled[next_idx];
    end

    // slot of an in-window segment: (base mod N) + (seq - base), wrapped once
    always_comb begin
        st_sum = {1'b0, idx_ext} + {1'b0, r_d[N_W-1:0]};
        st_red = st_sum - {1'b0, n};
        st_idx = (st_sum >= {1'b0, n}) ? st_red[IDX_W-1:0] : st_sum[IDX_W-1:0];
    end

    always_comb begin
        dlv_len = (r_state == ST_REL) ? mem_rdata.len : r_len;
        tot_sum = {1'b0, r_total} + (TOT_W + 1)'(dlv_len);
        tot_sat = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
    end

    assign out_free  = !r_ovalid || i_out_ready;
    assign rem_shift = {r_rem, r_base[r_cnt]};

    always_comb begin
        n_state    = r_state;
        n_win_size = r_win_size;
        n_base     = r_base;
        n_base_idx = r_base_idx;
        n_filled   = r_filled;
        n_total    = r_total;
        n_inord    = r_inord;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_seq      = r_seq;
        n_good     = r_good;
        n_len      = r_len;
        n_tag      = r_tag;
        n_d        = r_d;
        n_okind    = r_okind;
        n_oack     = r_oack;
        n_otag     = r_otag;
        n_olen     = r_olen;
        n_ototal   = r_ototal;
        n_olast    = r_olast;
        alu_req    = '{op: ALU_SUB, a: ALU_W'(r_seq), b: ALU_W'(r_base)};
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = st_idx;
        mem_wdata  = '{tag: r_tag, len: r_len};
        rem_next   = r_rem;
        // a window write takes the cycle; the waiting transaction stays put
        o_in_ready = (r_state == ST_IDLE) && !i_cfg_we;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_seq  = i_seq_num;
                    n_good = i_checksum_ok;
                    n_tag  = i_payload_tag;
                    n_len  = ({1'b0, i_length} > MAX_LEN) ? MAX_LEN[LEN_W-1:0] : i_length;
                    n_state = (i_kind == IN_KIND_END) ? ST_END : ST_CMP_BASE;
                end
            end
            ST_CMP_BASE: begin
                n_d = alu_res.sum;
                n_state = ({1'b0, r_seq} > SEQ_MAX) ? ST_IDLE : ST_CMP_WIN;
            end
            ST_CMP_WIN: begin
                n_state = ST_IDLE;
                if (r_d == '0) begin
                    if (r_good) begin
                        n_inord = 1'b1;
                        n_state = ST_ACK;
                    end
                end else if (!r_d[ALU_W-1]) begin
                    // later in window when seq - base < N
                    alu_req = '{op: ALU_SUB, a: r_d, b: ALU_W'(n)};
                    if (alu_res.neg && r_good) begin
                        mem_we           = 1'b1;
                        n_filled[st_idx] = 1'b1;
                        n_inord          = 1'b0;
                        n_state          = ST_ACK;
                    end
                end else begin
                    // previous window when N + (seq - base) >= 0
                    alu_req = '{op: ALU_ADD, a: ALU_W'(n), b: r_d};
                    if (!alu_res.neg) begin
                        n_inord = 1'b0;
                        n_state = ST_ACK;
                    end
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_ACK;
                    n_oack   = r_seq;
                    n_otag   = '0;
                    n_olen   = '0;
                    n_ototal = r_total;
                    n_olast  = !r_inord;
                    n_state  = r_inord ? ST_DLV : ST_IDLE;
                end
            end
            ST_DLV, ST_REL: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_DELIVER;
                    n_oack   = (r_state == ST_REL) ? r_base : r_seq;
                    n_otag   = (r_state == ST_REL) ? mem_rdata.tag : r_tag;
                    n_olen   = dlv_len;
                    n_ototal = tot_sat;
                    n_olast  = rel_last;
                    n_total  = tot_sat;
                    n_filled[r_base_idx] = 1'b0;
                    if (!base_at_max) begin
                        n_base = r_base + SEQ_W'(1);
                    end
                    n_base_idx = next_idx;
                    n_state    = rel_last ? ST_IDLE : ST_RD;
                end
            end
            ST_RD: begin
                mem_re  = 1'b1;
                n_state = ST_REL;
            end
            ST_END: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_END_ACK;
                    n_oack   = '0;
                    n_otag   = '0;
                    n_olen   = '0;
                    n_ototal = r_total;
                    n_olast  = 1'b1;
                    n_total  = '0;
                    n_filled = '0;
                    n_state  = ST_IDLE;
                end
            end
            ST_MOD: begin
                // restoring remainder, MSB first
                alu_req = '{op: ALU_SUB, a: ALU_W'(rem_shift), b: ALU_W'(n)};
                rem_next = alu_res.neg ? rem_shift[N_W-1:0] : alu_res.sum[N_W-1:0];
                n_rem = rem_next;
                n_cnt = r_cnt - BIT_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_base_idx = rem_next[IDX_W-1:0];
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_win_size = i_cfg_data;
            n_filled   = '0;
            n_rem      = '0;
            n_cnt      = '1;
            n_state    = ST_MOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_win_size <= WS_W'(1);
            r_base     <= SEQ_W'(1);
            r_base_idx <= '0;
            r_filled   <= '0;
            r_total    <= '0;
            r_inord    <= 1'b0;
            r_rem      <= '0;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_win_size <= n_win_size;
            r_base     <= n_base;
            r_base_idx <= n_base_idx;
            r_filled   <= n_filled;
            r_total    <= n_total;
            r_inord    <= n_inord;
            r_rem      <= n_rem;
            r_cnt      <= n_cnt;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq    <= n_seq;
        r_good   <= n_good;
        r_len    <= n_len;
        r_tag    <= n_tag;
        r_d      <= n_d;
        r_okind  <= n_okind;
        r_oack   <= n_oack;
        r_otag   <= n_otag;
        r_olen   <= n_olen;
        r_ototal <= n_ototal;
        r_olast  <= n_olast;
    end

    assign o_out_valid      = r_ovalid;
    assign o_out_kind       = r_okind;
    assign o_ack_num        = r_oack;
    assign o_deliver_tag    = r_otag;
    assign o_deliver_length = r_olen;
    assign o_total_bytes    = r_ototal;
    assign o_last           = r_olast;

`ifndef SYNTH
    // the window base only moves forward
    a_base_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_base >= $past(r_base)))
        else $error("window base moved backward");

    // base slot index is a valid remainder whenever a segment can be taken
    a_idx_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (idx_ext < n))
        else $error("base slot index outside window");

    // a new transaction is only taken once the previous one has emitted its final result
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && o_out_valid) |-> o_last)
        else $error("input ready while results of a segment are still pending");
`endif

endmodule
